@@ design/ucn_pkg.sv @@
// Shared types and constants of the UTF-8 / CJK text normalizer.
package ucn_pkg;

    // Number of command words held between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // Most bytes one input byte can produce: a space plus four UTF-8 bytes
    localparam int MAX_BYTES = 5;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Character codes
    localparam logic [7:0]  ASCII_SPACE = 8'h20;
    localparam logic [7:0]  ASCII_TAB   = 8'h09;
    localparam logic [7:0]  ASCII_LF    = 8'h0A;
    localparam logic [7:0]  ASCII_CR    = 8'h0D;
    localparam logic [7:0]  ASCII_QUEST = 8'h3F;
    localparam logic [7:0]  ASCII_LOW_A = 8'h61;
    localparam logic [7:0]  ASCII_LOW_Z = 8'h7A;
    localparam logic [20:0] CASE_OFFSET = 21'd32;

    // Command word from the front to the back: bytes[0] goes out first.
    // A count of zero marks the bare end-of-text word.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      last;
    } t_cmd;

endpackage

@@ design/ucn_front.sv @@
// Front end: UTF-8 decode, whitespace folding, CJK spacing, case fold and re-encode.
module ucn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_text,
    output logic          o_wr,
    output ucn_pkg::t_cmd o_cmd
);

    // Map listed CJK punctuation to ASCII
    function automatic logic [20:0] f_punct(input logic [20:0] c);
        logic [20:0] r;
        begin
            r = c;
            case (c)
                21'h0FF1A, 21'h0FF1B, 21'h0FF0C, 21'h03001: r = 21'h2C;
                21'h03002:                                  r = 21'h2E;
                21'h0FF01:                                  r = 21'h21;
                21'h0FF1F:                                  r = 21'h3F;
                21'h000B7, 21'h02014, 21'h0FF5E:            r = 21'h2D;
                21'h0201C, 21'h0201D, 21'h02018, 21'h02019,
                21'h0300C, 21'h0300D, 21'h0FF08, 21'h0FF09,
                21'h0300A, 21'h0300B, 21'h03010, 21'h03011: r = 21'h27;
                default:                                    r = c;
            endcase
            return r;
        end
    endfunction

    // CJK script ranges
    function automatic logic f_cjk(input logic [20:0] c);
        return (c >= 21'h01100 && c <= 21'h011FF) ||
               (c >= 21'h02E80 && c <= 21'h0A4CF) ||
               (c >= 21'h0A840 && c <= 21'h0D7AF) ||
               (c >= 21'h0F900 && c <= 21'h0FAFF) ||
               (c >= 21'h0FE30 && c <= 21'h0FE4F) ||
               (c >= 21'h0FF65 && c <= 21'h0FFDC) ||
               (c >= 21'h20000 && c <= 21'h2FFFF);
    endfunction

    logic [1:0]  r_rem, n_rem;
    logic [20:0] r_cp, n_cp;
    logic        r_lws, n_lws;
    logic        r_ps, n_ps;

    logic        have_char;
    logic [20:0] ch;
    logic        is_ws;
    logic [20:0] mapped;
    logic [20:0] enc_cp;
    logic        lead_sp;
    logic [3:0][7:0] enc;
    logic [2:0]  enc_cnt;

    // Decode: assemble the code point from lead and continuation bytes
    always_comb begin
        n_rem     = r_rem;
        n_cp      = r_cp;
        have_char = 1'b0;
        ch        = 21'd0;
        if (r_rem == 2'd0) begin
            if (!i_in_byte[7]) begin
                have_char = 1'b1;
                ch        = {13'd0, i_in_byte};
            end else if ((i_in_byte & 8'hE0) == 8'hC0) begin
                n_cp  = {16'd0, i_in_byte[4:0]};
                n_rem = 2'd1;
            end else if ((i_in_byte & 8'hF0) == 8'hE0) begin
                n_cp  = {17'd0, i_in_byte[3:0]};
                n_rem = 2'd2;
            end else if ((i_in_byte & 8'hF8) == 8'hF0) begin
                n_cp  = {18'd0, i_in_byte[2:0]};
                n_rem = 2'd3;
            end else begin
                have_char = 1'b1;
                ch        = {13'd0, ucn_pkg::ASCII_QUEST};
            end
        end else begin
            n_cp  = {r_cp[14:0], i_in_byte[5:0]};
            n_rem = r_rem - 2'd1;
            if (n_rem == 2'd0) begin
                have_char = 1'b1;
                ch        = n_cp;
            end
        end
    end

    // Classify: fold whitespace, map punctuation, space off CJK, upper-case
    always_comb begin
        n_lws   = r_lws;
        n_ps    = r_ps;
        lead_sp = 1'b0;
        is_ws   = (ch == {13'd0, ucn_pkg::ASCII_SPACE}) || (ch == {13'd0, ucn_pkg::ASCII_TAB}) ||
                  (ch == {13'd0, ucn_pkg::ASCII_LF})    || (ch == {13'd0, ucn_pkg::ASCII_CR});
        mapped  = f_punct(ch);
        enc_cp  = mapped;
        if (have_char) begin
            if (is_ws) begin
                if (!r_lws) begin
                    n_ps  = 1'b1;
                    n_lws = 1'b1;
                end
            end else if (f_cjk(mapped)) begin
                lead_sp = r_ps || !r_lws;
                n_ps    = 1'b1;
                n_lws   = 1'b1;
            end else begin
                if (mapped >= {13'd0, ucn_pkg::ASCII_LOW_A} &&
                    mapped <= {13'd0, ucn_pkg::ASCII_LOW_Z}) begin
                    enc_cp = mapped - ucn_pkg::CASE_OFFSET;
                end
                lead_sp = r_ps;
                n_ps    = 1'b0;
                n_lws   = 1'b0;
            end
        end
    end

    // Encode the code point in its shortest UTF-8 form
    always_comb begin
        enc = '0;
        if (enc_cp < 21'h80) begin
            enc[0]  = {1'b0, enc_cp[6:0]};
            enc_cnt = 3'd1;
        end else if (enc_cp < 21'h800) begin
            enc[0]  = {3'b110, enc_cp[10:6]};
            enc[1]  = {2'b10, enc_cp[5:0]};
            enc_cnt = 3'd2;
        end else if (enc_cp < 21'h10000) begin
            enc[0]  = {4'b1110, enc_cp[15:12]};
            enc[1]  = {2'b10, enc_cp[11:6]};
            enc[2]  = {2'b10, enc_cp[5:0]};
            enc_cnt = 3'd3;
        end else begin
            enc[0]  = {5'b11110, enc_cp[20:18]};
            enc[1]  = {2'b10, enc_cp[17:12]};
            enc[2]  = {2'b10, enc_cp[11:6]};
            enc[3]  = {2'b10, enc_cp[5:0]};
            enc_cnt = 3'd4;
        end
    end

    // Build the command word, with the held space in front when due
    always_comb begin
        o_cmd      = '0;
        o_cmd.last = i_end_of_text;
        if (have_char && !is_ws) begin
            if (lead_sp) begin
                o_cmd.bytes[0] = ucn_pkg::ASCII_SPACE;
                o_cmd.bytes[1] = enc[0];
                o_cmd.bytes[2] = enc[1];
                o_cmd.bytes[3] = enc[2];
                o_cmd.bytes[4] = enc[3];
                o_cmd.count    = ucn_pkg::CNT_W'(enc_cnt) + ucn_pkg::CNT_W'(1);
            end else begin
                o_cmd.bytes[0] = enc[0];
                o_cmd.bytes[1] = enc[1];
                o_cmd.bytes[2] = enc[2];
                o_cmd.bytes[3] = enc[3];
                o_cmd.count    = ucn_pkg::CNT_W'(enc_cnt);
            end
        end
        o_wr = i_accept && ((have_char && !is_ws) || i_end_of_text);
    end

    // Advance decoder state; return to reset values after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
            r_cp  <= '0;
            r_lws <= 1'b1;
            r_ps  <= 1'b0;
        end else if (i_accept) begin
            if (i_end_of_text) begin
                r_rem <= 2'd0;
                r_cp  <= '0;
                r_lws <= 1'b1;
                r_ps  <= 1'b0;
            end else begin
                r_rem <= n_rem;
                r_cp  <= n_cp;
                r_lws <= n_lws;
                r_ps  <= n_ps;
            end
        end
    end

endmodule

@@ design/ucn_queue.sv @@
// Small command queue between the front and the back.
module ucn_queue #(
    parameter int DEPTH = ucn_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  ucn_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output ucn_pkg::t_cmd o_rdata,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ucn_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // Store a word at the write pointer
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

@@ design/ucn_back.sv @@
// Back end: serialize command words into output bytes through an output register.
module ucn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ucn_pkg::t_cmd i_cmd,
    input  logic          i_q_empty,
    output logic          o_q_rd,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_valid,
    output logic          o_last
);

    ucn_pkg::t_cmd             r_cmd;
    logic                      r_busy;
    logic [ucn_pkg::CNT_W-1:0] r_idx;
    logic                      r_full;
    logic [7:0]                r_byte;
    logic                      r_bval;
    logic                      r_last;

    logic out_free, emit, final_byte, load;

    // Step one byte whenever the output register is free or being taken
    always_comb begin
        out_free   = !r_full || i_pop;
        emit       = r_busy && out_free;
        final_byte = (r_cmd.count == '0) ||
                     (r_idx == r_cmd.count - ucn_pkg::CNT_W'(1));
        load       = (!r_busy || (emit && final_byte)) && !i_q_empty;
        o_q_rd     = load;
    end

    // Hold the current word and walk its bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (emit) begin
            if (final_byte) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + ucn_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    // Output register: load a byte or drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (emit) begin
            r_full <= 1'b1;
        end else if (i_pop) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= (r_cmd.count == '0) ? 8'h00 : r_cmd.bytes[r_idx];
            r_bval <= (r_cmd.count != '0);
            r_last <= r_cmd.last && final_byte;
        end
    end

    assign o_empty      = !r_full;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_bval;
    assign o_last       = r_last;

endmodule

@@ design/utf8_cjk_text_normalizer.sv @@
// UTF-8 / CJK text normalizer top level.
//
// Input channel: raw UTF-8 text, one word per cycle (i_in_byte, i_end_of_text),
// taken when push is high and full is low. Output channel: normalized UTF-8,
// one word per cycle (o_out_byte, o_byte_valid, o_last), shown while empty is
// low and taken when pop is high.
// The front decodes, classifies and re-encodes each input byte in the cycle it
// is taken and writes at most one command word of up to five output bytes into
// a queue of QUEUE_DEPTH words. The back emits one output byte per cycle while
// its output register is free or being taken. The first output byte of an
// input passes through the queue, the back's word register and the output
// register. The back bounds throughput; plain text runs one per cycle.
// A word with o_byte_valid low and o_last high is the bare end marker, given
// when the final input byte yields no output byte.
// When pop stays low the output register holds its word, the back stops and
// the queue fills; full then rises and stalls the sender.
// Synchronous reset (i_rst_n low) empties the queue and output register and
// returns the decoder to its idle state; the block accepts input the next cycle.
module utf8_cjk_text_normalizer #(
    parameter int QUEUE_DEPTH = ucn_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last
);

    ucn_pkg::t_cmd wr_cmd, rd_cmd;
    logic          q_wr, q_rd, q_full, q_empty;

    assign full = q_full;

    ucn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (push && !q_full),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_wr          (q_wr),
        .o_cmd         (wr_cmd)
    );

    ucn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (wr_cmd),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (rd_cmd),
        .o_empty (q_empty)
    );

    ucn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (rd_cmd),
        .i_q_empty    (q_empty),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last)
    );

endmodule

@@ design/ucn_checker.sv @@
// Port-level checker of the text normalizer and its bind to the top level.
module ucn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_last
);

    // Reset leaves no word on the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // A stalled output word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) &&
                              $stable(o_byte_valid) && $stable(o_last)))
        else $error("output word changed while stalled");

    // The bare end marker is zero and closes the text
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_last && o_out_byte == 8'h00))
        else $error("malformed end marker");

    // Lower-case ASCII never leaves the block
    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_valid) |-> !(o_out_byte >= 8'h61 && o_out_byte <= 8'h7A))
        else $error("lower-case letter on output");

endmodule

bind utf8_cjk_text_normalizer ucn_checker u_ucn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_last       (o_last)
);

@@ dv/utf8_cjk_text_normalizer_tb.sv @@
// Self-checking testbench of the UTF-8 / CJK text normalizer.
module utf8_cjk_text_normalizer_tb;

    // One normalized output word as seen on the result ports
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
    } t_out_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       i_end_of_text;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_last;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int bytes_sent;

    // Split a code point into its shortest UTF-8 form
    function automatic void utf8_bytes(input logic [20:0] cp, output logic [7:0] b[4],
                                       output int n);
        b = '{default: 8'h00};
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
            n = 1;
        end else if (cp < 21'h800) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp < 21'h10000) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
            n = 4;
        end
    endfunction

    class norm_scoreboard;
        t_out_word   pending_out_bytes[$];
        int          mismatches;
        logic [1:0]  cont_left;
        logic [20:0] cp_acc;
        bit          after_sep;
        bit          space_held;

        function new();
            mismatches = 0;
            clear_text();
        endfunction

        function void clear_text();
            cont_left  = 2'd0;
            cp_acc     = 21'd0;
            after_sep  = 1'b1;
            space_held = 1'b0;
        endfunction

        function bit is_cjk(logic [20:0] c);
            return (c >= 21'h1100 && c <= 21'h11FF) || (c >= 21'h2E80 && c <= 21'hA4CF) ||
                   (c >= 21'hA840 && c <= 21'hD7AF) || (c >= 21'hF900 && c <= 21'hFAFF) ||
                   (c >= 21'hFE30 && c <= 21'hFE4F) || (c >= 21'hFF65 && c <= 21'hFFDC) ||
                   (c >= 21'h20000 && c <= 21'h2FFFF);
        endfunction

        // Fold full-width and CJK punctuation onto plain ASCII
        function logic [20:0] fold_punct(logic [20:0] c);
            case (c)
                21'hFF1A, 21'hFF1B, 21'hFF0C, 21'h3001: return 21'h2C;  // comma
                21'h3002:                               return 21'h2E;  // period
                21'hFF01:                               return 21'h21;  // bang
                21'hFF1F:                               return 21'h3F;  // question
                21'h00B7, 21'h2014, 21'hFF5E:           return 21'h2D;  // dash
                21'h201C, 21'h201D, 21'h2018, 21'h2019,
                21'h300C, 21'h300D, 21'hFF08, 21'hFF09,
                21'h300A, 21'h300B, 21'h3010, 21'h3011: return 21'h27;  // quote
                default:                                return c;
            endcase
        endfunction

        // Append one expected word at the tail
        function void add_word(t_out_word w);
            pending_out_bytes.insert(pending_out_bytes.size(), w);
        endfunction

        function void put_byte(logic [7:0] b);
            t_out_word w;
            w.out_byte   = b;
            w.byte_valid = 1'b1;
            w.last       = 1'b0;
            add_word(w);
        endfunction

        function void put_char(logic [20:0] c);
            logic [7:0] b[4];
            int         n;
            utf8_bytes(c, b, n);
            for (int k = 0; k < n; k++) put_byte(b[k]);
        endfunction

        // Normalize one complete code point
        function void normalize_code_point(logic [20:0] c);
            logic [20:0] m;
            if (c == ucn_pkg::ASCII_SPACE || c == ucn_pkg::ASCII_TAB ||
                c == ucn_pkg::ASCII_LF || c == ucn_pkg::ASCII_CR) begin
                if (!after_sep) begin
                    space_held = 1'b1;
                    after_sep  = 1'b1;
                end
                return;
            end
            m = fold_punct(c);
            if (is_cjk(m)) begin
                if (space_held || !after_sep) put_byte(ucn_pkg::ASCII_SPACE);
                put_char(m);
                space_held = 1'b1;
                after_sep  = 1'b1;
            end else begin
                if (m >= ucn_pkg::ASCII_LOW_A && m <= ucn_pkg::ASCII_LOW_Z)
                    m = m - ucn_pkg::CASE_OFFSET;
                if (space_held) put_byte(ucn_pkg::ASCII_SPACE);
                put_char(m);
                space_held = 1'b0;
                after_sep  = 1'b0;
            end
        endfunction

        // Decode one accepted input byte and queue the bytes it yields
        function void add_input_byte(logic [7:0] b, logic eot);
            t_out_word w;
            int        n0;
            n0 = pending_out_bytes.size();
            if (cont_left == 2'd0) begin
                if (!b[7]) begin
                    normalize_code_point({13'd0, b});
                end else if (b[7:5] == 3'b110) begin
                    cp_acc    = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    cp_acc    = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    cp_acc    = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end else begin
                    normalize_code_point({13'd0, ucn_pkg::ASCII_QUEST});
                end
            end else begin
                // Take any byte as a continuation, low six bits only
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) normalize_code_point(cp_acc);
            end
            if (eot) begin
                if (pending_out_bytes.size() == n0) begin
                    w.out_byte   = 8'h00;
                    w.byte_valid = 1'b0;
                    w.last       = 1'b1;
                    add_word(w);
                end else begin
                    pending_out_bytes[pending_out_bytes.size() - 1].last = 1'b1;
                end
                clear_text();
            end
        endfunction

        function void check_output_byte(logic [7:0] ob, logic bv, logic lst);
            t_out_word w;
            if (pending_out_bytes.size() == 0) begin
                $error("word with nothing expected: out_byte %h byte_valid %b last %b",
                       ob, bv, lst);
                mismatches++;
                return;
            end
            w = pending_out_bytes.pop_front();
            if (ob !== w.out_byte) begin
                $error("out_byte: expected %h, got %h", w.out_byte, ob);
                mismatches++;
            end
            if (bv !== w.byte_valid) begin
                $error("byte_valid: expected %b, got %b", w.byte_valid, bv);
                mismatches++;
            end
            if (lst !== w.last) begin
                $error("last: expected %b, got %b", w.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    norm_scoreboard sb = new();

    // Directed text: {end_of_text, byte}
    logic [8:0] directed_text[25] = '{
        {1'b0, 8'h61}, {1'b0, 8'h7A}, {1'b0, 8'h09}, {1'b0, 8'h0D}, {1'b0, 8'h0A},
        {1'b0, 8'h20}, {1'b0, 8'h00}, {1'b0, 8'h7F}, {1'b0, 8'h80}, {1'b0, 8'hFF},
        {1'b0, 8'hC0}, {1'b0, 8'h80}, {1'b0, 8'hE3}, {1'b0, 8'h80}, {1'b0, 8'h82},
        {1'b0, 8'hE4}, {1'b0, 8'hB8}, {1'b0, 8'hAD}, {1'b0, 8'hF0}, {1'b0, 8'hA0},
        {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'hF8}, {1'b1, 8'h20}, {1'b1, 8'hE4}
    };

    logic [20:0] punct_pts[22] = '{
        21'hFF1A, 21'hFF1B, 21'hFF0C, 21'h3001, 21'h3002, 21'hFF01, 21'hFF1F, 21'h00B7,
        21'h2014, 21'hFF5E, 21'h201C, 21'h201D, 21'h2018, 21'h2019, 21'h300C, 21'h300D,
        21'hFF08, 21'hFF09, 21'h300A, 21'h300B, 21'h3010, 21'h3011
    };

    logic [7:0] blank_pts[4] = '{ucn_pkg::ASCII_SPACE, ucn_pkg::ASCII_TAB,
                                 ucn_pkg::ASCII_LF, ucn_pkg::ASCII_CR};

    utf8_cjk_text_normalizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .i_end_of_text(i_end_of_text),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watch both handshakes on the edge
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) sb.add_input_byte(i_in_byte, i_end_of_text);
        if (i_rst_n && pop && !empty) sb.check_output_byte(o_out_byte, o_byte_valid, o_last);
    end

    // Drain the result side, with random stalls and an optional long hold
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one word and hold it until it is taken
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send one random character, mostly well formed
    task automatic send_char();
        int          pick;
        int          n;
        int          cut;
        logic [20:0] cp;
        logic [7:0]  b[4];
        logic        eot_here;
        pick = $urandom_range(99);
        if (pick < 25)      cp = 21'($urandom_range(8'h21, 8'h7E));
        else if (pick < 35) cp = {13'd0, blank_pts[$urandom_range(3)]};
        else if (pick < 55) cp = 21'($urandom_range(21'h2E80, 21'hA4CF));
        else if (pick < 65) cp = punct_pts[$urandom_range(21)];
        else if (pick < 72) cp = 21'($urandom_range(21'h80, 21'h7FF));
        else if (pick < 76) cp = 21'($urandom_range(21'h20000, 21'h2FFFF));
        else if (pick < 80) cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
        else if (pick < 86) cp = 21'($urandom_range(21'h800, 21'hFFFF));
        else if (pick < 93) cp = 21'($urandom_range(0, 8'h7F));
        else if (pick < 97) cp = 21'($urandom_range(21'h800, 21'h1FFFFF));
        else begin
            // Raw noise byte
            send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
            return;
        end
        utf8_bytes(cp, b, n);
        cut = n;
        // Break the sequence short
        if (pick >= 93) cut = $urandom_range(1, n - 1);
        eot_here = ($urandom_range(9) == 0);
        for (int k = 0; k < cut; k++) send_byte(b[k], eot_here && (k == cut - 1));
    endtask

    task automatic send_text(input int upto);
        while (bytes_sent < upto) send_char();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_in_byte     = 8'h00;
        i_end_of_text = 1'b0;
        hold_left     = 0;
        bytes_sent    = 0;
        send_idle_pct = 16;
        recv_idle_pct = 84;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners, then random text with slow receiver
        foreach (directed_text[k]) send_byte(directed_text[k][7:0], directed_text[k][8]);
        send_text(60);

        // Slow sender
        send_idle_pct = 84;
        recv_idle_pct = 16;
        send_text(95);

        // No idling; hold the receiver off so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 60;
        send_text(130);
        push <= 1'b0;

        while (sb.pending_out_bytes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ utf8_cjk_text_normalizer.f @@
design/ucn_pkg.sv
design/ucn_front.sv
design/ucn_queue.sv
design/ucn_back.sv
design/utf8_cjk_text_normalizer.sv
design/ucn_checker.sv
dv/utf8_cjk_text_normalizer_tb.sv
